// ----- rtl/lio_pkg.sv -----
`timescale 1ns / 1ps

package lio_pkg;

    // Fixed field widths of the ports
    localparam int DIM_W     = 7;
    localparam int CFG_IDX_W = 4;
    localparam int OUT_W     = 13;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_GRID_ROWS = 4'd0,
        CFG_GRID_COLS = 4'd1
    } cfg_idx_t;

    // Neighbor directions, in visiting order
    typedef enum logic [1:0] {
        DIR_UP    = 2'd0,
        DIR_DOWN  = 2'd1,
        DIR_LEFT  = 2'd2,
        DIR_RIGHT = 2'd3
    } dir_t;

endpackage

// ----- rtl/lio_nbr.sv -----
`timescale 1ns / 1ps

module lio_nbr
    import lio_pkg::*;
#(
    parameter int AW = 12,
    parameter int RW = 6,
    parameter int CW = 6
) (
    input  logic [AW-1:0] pos,
    input  logic [RW-1:0] row,
    input  logic [CW-1:0] col,
    input  dir_t          dir,
    input  logic [RW-1:0] rows_m1,
    input  logic [CW-1:0] cols_m1,
    output logic          nb_ok,
    output logic [AW-1:0] nb_pos,
    output logic [RW-1:0] nb_row,
    output logic [CW-1:0] nb_col
);

    logic [AW-1:0] cols_aw;

    assign cols_aw = AW'(cols_m1) + AW'(1);

    // Step one cell; flag steps that leave the grid
    always_comb begin
        nb_ok  = 1'b0;
        nb_pos = pos;
        nb_row = row;
        nb_col = col;
        unique case (dir)
            DIR_UP:
            begin
                nb_ok  = (row != '0);
                nb_pos = pos - cols_aw;
                nb_row = row - RW'(1);
            end
            DIR_DOWN:
            begin
                nb_ok  = (row != rows_m1);
                nb_pos = pos + cols_aw;
                nb_row = row + RW'(1);
            end
            DIR_LEFT:
            begin
                nb_ok  = (col != '0);
                nb_pos = pos - AW'(1);
                nb_col = col - CW'(1);
            end
            DIR_RIGHT:
            begin
                nb_ok  = (col != cols_m1);
                nb_pos = pos + AW'(1);
                nb_col = col + CW'(1);
            end
            default:
            begin
                nb_ok = 1'b0;
            end
        endcase
    end

endmodule

// ----- rtl/largest_island_one_flip.sv -----
`timescale 1ns / 1ps

// Largest island after flipping at most one water cell.
//
// Input channel (in_valid / in_stall / cell_value): one beat per grid cell in
// raster order, 1 land, 0 water. Cells load one per cycle; in_stall rises
// once the last cell of the grid is in and stays high while the grid is
// evaluated and until its result enters the output register.
// Output channel (out_valid / out_stall / largest_area): one beat per grid.
// Configuration channel (cfg_valid / cfg_ready / cfg_index / cfg_data): index 0
// sets the row count, index 1 the column count; zero acts as one, values above
// MAX_ROWS / MAX_COLS saturate. A write to index 0 or 1 restarts the load at
// cell zero; writes to other indexes are accepted and dropped.
// cfg_ready is high only while cells are loading.
// After the last cell, the label pass flood-fills each new island through
// the fill stack, visiting the neighbors of each popped land cell; the water
// pass adds up the areas of the distinct islands around each water cell; then
// the result is emitted. Each neighbor visit is one read of the cell memory's
// single read port, which sets the pace.
// Reset: grid is 64 by 64, load position zero, no result pending.
// A stalled result holds in the output register; loading of the next grid
// goes on, and the block only waits if that grid finishes first.
module largest_island_one_flip
    import lio_pkg::*;
#(
    parameter int MAX_ROWS = 64,
    parameter int MAX_COLS = 64
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic                 cell_value,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [OUT_W-1:0]     largest_area,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [DIM_W-1:0]     cfg_data
);

    localparam int DEPTH  = MAX_ROWS * MAX_COLS;
    localparam int AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int RW     = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int CW     = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int AREA_W = $clog2(DEPTH + 1);
    localparam int SPW    = $clog2(DEPTH + 1);
    localparam int SW     = AW + RW + CW;
    localparam int ROWS_RST = (64 > MAX_ROWS) ? MAX_ROWS : 64;
    localparam int COLS_RST = (64 > MAX_COLS) ? MAX_COLS : 64;

    typedef enum logic [3:0] {
        S_LOAD,
        S_L_RD,
        S_L_CHK,
        S_POP,
        S_POP_D,
        S_NB,
        S_NB_D,
        S_FIN,
        S_W_RD,
        S_W_CHK,
        S_W_NB,
        S_W_NB_D,
        S_W_AREA,
        S_W_FIN,
        S_EMIT
    } state_t;

    state_t              state_reg;
    logic [RW-1:0]       rows_m1_reg;
    logic [CW-1:0]       cols_m1_reg;
    logic [AW-1:0]       p_reg;
    logic [RW-1:0]       pr_reg;
    logic [CW-1:0]       pc_reg;
    logic [SPW-1:0]      sp_reg;
    logic [AW-1:0]       q_reg;
    logic [RW-1:0]       qr_reg;
    logic [CW-1:0]       qc_reg;
    logic [AW-1:0]       nb_reg;
    logic [RW-1:0]       nr_reg;
    logic [CW-1:0]       nc_reg;
    dir_t                dir_reg;
    logic [AREA_W-1:0]   area_cnt_reg;
    logic [AREA_W-1:0]   best_reg;
    logic [AREA_W-1:0]   sum_reg;
    logic [AW-1:0]       seen_reg [4];
    logic [2:0]          seen_cnt_reg;
    logic                out_valid_reg;
    logic [OUT_W-1:0]    out_area_reg;

    // Memories: {visited, land}, label per cell, area per label, fill stack
    logic [1:0]          cell_mem [DEPTH];
    logic [AW-1:0]       lab_mem  [DEPTH];
    logic [AREA_W-1:0]   area_mem [DEPTH];
    logic [SW-1:0]       stk_mem  [DEPTH];
    logic [1:0]          cell_rdata_reg;
    logic [AW-1:0]       lab_rdata_reg;
    logic [AREA_W-1:0]   area_rdata_reg;
    logic [SW-1:0]       stk_rdata_reg;

    logic                cell_we;
    logic [AW-1:0]       cell_waddr;
    logic [1:0]          cell_wdata;
    logic [AW-1:0]       cell_raddr;
    logic                lab_we;
    logic [AW-1:0]       lab_waddr;
    logic [AW-1:0]       lab_raddr;
    logic                area_we;
    logic [AW-1:0]       area_raddr;
    logic                stk_we;
    logic [AW-1:0]       stk_waddr;
    logic [SW-1:0]       stk_wdata;
    logic [AW-1:0]       stk_raddr;

    logic                in_acc;
    logic                cfg_acc;
    logic                cfg_known;
    logic                p_last;
    logic [31:0]         cfg_dim;
    logic [31:0]         rows_clamp;
    logic [31:0]         cols_clamp;

    logic [AW-1:0]       base_pos;
    logic [RW-1:0]       base_row;
    logic [CW-1:0]       base_col;
    logic                nb_ok;
    logic [AW-1:0]       nb_pos;
    logic [RW-1:0]       nb_row;
    logic [CW-1:0]       nb_col;
    logic                seen_dup;

    assign in_stall     = (state_reg != S_LOAD);
    assign in_acc       = in_valid && !in_stall;
    assign cfg_ready    = (state_reg == S_LOAD);
    assign cfg_acc      = cfg_valid && cfg_ready;
    assign cfg_known    = (cfg_index == CFG_GRID_ROWS) || (cfg_index == CFG_GRID_COLS);
    assign p_last       = (pr_reg == rows_m1_reg) && (pc_reg == cols_m1_reg);
    assign out_valid    = out_valid_reg;
    assign largest_area = out_area_reg;

    // Clamp a written dimension: zero acts as one, saturate at the bound
    always_comb
    begin
        cfg_dim    = 32'(cfg_data);
        rows_clamp = (cfg_dim == 32'd0) ? 32'd1 :
                     (cfg_dim > 32'(MAX_ROWS)) ? 32'(MAX_ROWS) : cfg_dim;
        cols_clamp = (cfg_dim == 32'd0) ? 32'd1 :
                     (cfg_dim > 32'(MAX_COLS)) ? 32'(MAX_COLS) : cfg_dim;
    end

    // Label pass walks from the popped cell, water pass from the scan cell
    always_comb
    begin
        if (state_reg == S_W_NB)
        begin
            base_pos = p_reg;
            base_row = pr_reg;
            base_col = pc_reg;
        end
        else
        begin
            base_pos = q_reg;
            base_row = qr_reg;
            base_col = qc_reg;
        end
    end

    lio_nbr #(
        .AW (AW),
        .RW (RW),
        .CW (CW)
    ) u_nbr (
        .pos     (base_pos),
        .row     (base_row),
        .col     (base_col),
        .dir     (dir_reg),
        .rows_m1 (rows_m1_reg),
        .cols_m1 (cols_m1_reg),
        .nb_ok   (nb_ok),
        .nb_pos  (nb_pos),
        .nb_row  (nb_row),
        .nb_col  (nb_col)
    );

    // A neighbor label already counted for this water cell
    always_comb
    begin
        seen_dup = 1'b0;
        for (int k = 0; k < 4; k++)
        begin
            if ((3'(k) < seen_cnt_reg) && (seen_reg[k] == lab_rdata_reg))
            begin
                seen_dup = 1'b1;
            end
        end
    end

    // Memory port control
    always_comb
    begin
        cell_we    = 1'b0;
        cell_waddr = p_reg;
        cell_wdata = {1'b0, cell_value};
        cell_raddr = p_reg;
        lab_we     = 1'b0;
        lab_waddr  = stk_rdata_reg[SW-1 -: AW];
        lab_raddr  = nb_pos;
        area_we    = 1'b0;
        area_raddr = lab_rdata_reg;
        stk_we     = 1'b0;
        stk_waddr  = AW'(sp_reg);
        stk_wdata  = {p_reg, pr_reg, pc_reg};
        stk_raddr  = AW'(sp_reg - SPW'(1));
        unique case (state_reg)
            S_LOAD:
            begin
                cell_we = in_acc;
            end
            S_L_CHK:
            begin
                if (cell_rdata_reg == 2'b01)
                begin
                    cell_we    = 1'b1;
                    cell_wdata = 2'b11;
                    stk_we     = 1'b1;
                    stk_waddr  = '0;
                end
            end
            S_POP_D:
            begin
                lab_we = 1'b1;
            end
            S_NB:
            begin
                cell_raddr = nb_pos;
            end
            S_NB_D:
            begin
                if (cell_rdata_reg == 2'b01)
                begin
                    cell_we    = 1'b1;
                    cell_waddr = nb_reg;
                    cell_wdata = 2'b11;
                    stk_we     = 1'b1;
                    stk_wdata  = {nb_reg, nr_reg, nc_reg};
                end
            end
            S_FIN:
            begin
                area_we = (sp_reg == '0);
            end
            S_W_NB:
            begin
                cell_raddr = nb_pos;
            end
            default:
            begin
                cell_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cell_we)
        begin
            cell_mem[cell_waddr] <= cell_wdata;
        end
        cell_rdata_reg <= cell_mem[cell_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (lab_we)
        begin
            lab_mem[lab_waddr] <= p_reg;
        end
        lab_rdata_reg <= lab_mem[lab_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (area_we)
        begin
            area_mem[p_reg] <= area_cnt_reg;
        end
        area_rdata_reg <= area_mem[area_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (stk_we)
        begin
            stk_mem[stk_waddr] <= stk_wdata;
        end
        stk_rdata_reg <= stk_mem[stk_raddr];
    end

    // Sequencer: load, label pass, water pass, emit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_LOAD;
            rows_m1_reg   <= RW'(ROWS_RST - 1);
            cols_m1_reg   <= CW'(COLS_RST - 1);
            p_reg         <= '0;
            pr_reg        <= '0;
            pc_reg        <= '0;
            sp_reg        <= '0;
            q_reg         <= '0;
            qr_reg        <= '0;
            qc_reg        <= '0;
            nb_reg        <= '0;
            nr_reg        <= '0;
            nc_reg        <= '0;
            dir_reg       <= DIR_UP;
            area_cnt_reg  <= '0;
            best_reg      <= '0;
            sum_reg       <= '0;
            seen_cnt_reg  <= '0;
            for (int k = 0; k < 4; k++)
            begin
                seen_reg[k] <= '0;
            end
            out_valid_reg <= 1'b0;
            out_area_reg  <= '0;
        end
        else
        begin
            // Load the answer once the register frees up, drop it once taken
            if ((state_reg == S_EMIT) && (!out_valid_reg || !out_stall))
            begin
                out_valid_reg <= 1'b1;
                out_area_reg  <= OUT_W'(best_reg);
            end
            else if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_LOAD:
                begin
                    if (cfg_acc && cfg_known)
                    begin
                        if (cfg_index == CFG_GRID_ROWS)
                        begin
                            rows_m1_reg <= RW'(rows_clamp - 32'd1);
                        end
                        else
                        begin
                            cols_m1_reg <= CW'(cols_clamp - 32'd1);
                        end
                        p_reg  <= '0;
                        pr_reg <= '0;
                        pc_reg <= '0;
                    end
                    else if (in_acc)
                    begin
                        if (p_last)
                        begin
                            p_reg     <= '0;
                            pr_reg    <= '0;
                            pc_reg    <= '0;
                            best_reg  <= '0;
                            state_reg <= S_L_RD;
                        end
                        else
                        begin
                            p_reg <= p_reg + AW'(1);
                            if (pc_reg == cols_m1_reg)
                            begin
                                pc_reg <= '0;
                                pr_reg <= pr_reg + RW'(1);
                            end
                            else
                            begin
                                pc_reg <= pc_reg + CW'(1);
                            end
                        end
                    end
                end
                S_L_RD:
                begin
                    state_reg <= S_L_CHK;
                end
                S_L_CHK:
                begin
                    if (cell_rdata_reg == 2'b01)
                    begin
                        // Seed a new component at the scan cell
                        sp_reg       <= SPW'(1);
                        area_cnt_reg <= '0;
                        state_reg    <= S_POP;
                    end
                    else if (p_last)
                    begin
                        p_reg     <= '0;
                        pr_reg    <= '0;
                        pc_reg    <= '0;
                        state_reg <= S_W_RD;
                    end
                    else
                    begin
                        p_reg <= p_reg + AW'(1);
                        if (pc_reg == cols_m1_reg)
                        begin
                            pc_reg <= '0;
                            pr_reg <= pr_reg + RW'(1);
                        end
                        else
                        begin
                            pc_reg <= pc_reg + CW'(1);
                        end
                        state_reg <= S_L_RD;
                    end
                end
                S_POP:
                begin
                    sp_reg    <= sp_reg - SPW'(1);
                    state_reg <= S_POP_D;
                end
                S_POP_D:
                begin
                    {q_reg, qr_reg, qc_reg} <= stk_rdata_reg;
                    area_cnt_reg <= area_cnt_reg + AREA_W'(1);
                    dir_reg      <= DIR_UP;
                    state_reg    <= S_NB;
                end
                S_NB:
                begin
                    if (nb_ok)
                    begin
                        nb_reg    <= nb_pos;
                        nr_reg    <= nb_row;
                        nc_reg    <= nb_col;
                        state_reg <= S_NB_D;
                    end
                    else if (dir_reg == DIR_RIGHT)
                    begin
                        state_reg <= S_FIN;
                    end
                    else
                    begin
                        dir_reg <= dir_t'(dir_reg + 2'd1);
                    end
                end
                S_NB_D:
                begin
                    if (cell_rdata_reg == 2'b01)
                    begin
                        sp_reg <= sp_reg + SPW'(1);
                    end
                    if (dir_reg == DIR_RIGHT)
                    begin
                        state_reg <= S_FIN;
                    end
                    else
                    begin
                        dir_reg   <= dir_t'(dir_reg + 2'd1);
                        state_reg <= S_NB;
                    end
                end
                S_FIN:
                begin
                    if (sp_reg != '0)
                    begin
                        state_reg <= S_POP;
                    end
                    else
                    begin
                        if (area_cnt_reg > best_reg)
                        begin
                            best_reg <= area_cnt_reg;
                        end
                        if (p_last)
                        begin
                            p_reg     <= '0;
                            pr_reg    <= '0;
                            pc_reg    <= '0;
                            state_reg <= S_W_RD;
                        end
                        else
                        begin
                            p_reg <= p_reg + AW'(1);
                            if (pc_reg == cols_m1_reg)
                            begin
                                pc_reg <= '0;
                                pr_reg <= pr_reg + RW'(1);
                            end
                            else
                            begin
                                pc_reg <= pc_reg + CW'(1);
                            end
                            state_reg <= S_L_RD;
                        end
                    end
                end
                S_W_RD:
                begin
                    state_reg <= S_W_CHK;
                end
                S_W_CHK:
                begin
                    if (cell_rdata_reg[0])
                    begin
                        state_reg <= S_W_FIN;
                        sum_reg   <= '0;
                    end
                    else
                    begin
                        sum_reg      <= AREA_W'(1);
                        seen_cnt_reg <= '0;
                        dir_reg      <= DIR_UP;
                        state_reg    <= S_W_NB;
                    end
                end
                S_W_NB:
                begin
                    if (nb_ok)
                    begin
                        state_reg <= S_W_NB_D;
                    end
                    else if (dir_reg == DIR_RIGHT)
                    begin
                        state_reg <= S_W_FIN;
                    end
                    else
                    begin
                        dir_reg <= dir_t'(dir_reg + 2'd1);
                    end
                end
                S_W_NB_D:
                begin
                    if (cell_rdata_reg[0] && !seen_dup)
                    begin
                        seen_reg[seen_cnt_reg[1:0]] <= lab_rdata_reg;
                        seen_cnt_reg <= seen_cnt_reg + 3'd1;
                        state_reg    <= S_W_AREA;
                    end
                    else if (dir_reg == DIR_RIGHT)
                    begin
                        state_reg <= S_W_FIN;
                    end
                    else
                    begin
                        dir_reg   <= dir_t'(dir_reg + 2'd1);
                        state_reg <= S_W_NB;
                    end
                end
                S_W_AREA:
                begin
                    sum_reg <= sum_reg + area_rdata_reg;
                    if (dir_reg == DIR_RIGHT)
                    begin
                        state_reg <= S_W_FIN;
                    end
                    else
                    begin
                        dir_reg   <= dir_t'(dir_reg + 2'd1);
                        state_reg <= S_W_NB;
                    end
                end
                S_W_FIN:
                begin
                    if (sum_reg > best_reg)
                    begin
                        best_reg <= sum_reg;
                    end
                    if (p_last)
                    begin
                        p_reg     <= '0;
                        pr_reg    <= '0;
                        pc_reg    <= '0;
                        state_reg <= S_EMIT;
                    end
                    else
                    begin
                        p_reg <= p_reg + AW'(1);
                        if (pc_reg == cols_m1_reg)
                        begin
                            pc_reg <= '0;
                            pr_reg <= pr_reg + RW'(1);
                        end
                        else
                        begin
                            pc_reg <= pc_reg + CW'(1);
                        end
                        state_reg <= S_W_RD;
                    end
                end
                S_EMIT:
                begin
                    // Hold until the previous result is gone
                    if (!out_valid_reg || !out_stall)
                    begin
                        state_reg <= S_LOAD;
                    end
                end
                default:
                begin
                    state_reg <= S_LOAD;
                end
            endcase
        end
    end

    // The fill stack never holds more cells than the largest grid has
    assert property (@(posedge clk) disable iff (!rst_n)
        sp_reg <= SPW'(DEPTH))
        else $error("fill stack overflow");

    // A pop is only issued with a non-empty stack
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_POP) |-> (sp_reg != '0))
        else $error("pop from empty stack");

    // At most four distinct neighbor labels per water cell
    assert property (@(posedge clk) disable iff (!rst_n)
        seen_cnt_reg <= 3'd4)
        else $error("too many neighbor labels");

    // Every grid has at least one cell, so an answer is never zero
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EMIT) |-> (best_reg != '0))
        else $error("empty answer at emit");

    // The scan position holds while a scan read moves on to its check
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_L_RD) |=> (state_reg == S_L_CHK) && $stable(p_reg))
        else $error("scan position moved during read");

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps

module testbench
    import lio_pkg::*;
();

    localparam int MAX_DIM    = 64;
    localparam int CELLS      = MAX_DIM * MAX_DIM;
    localparam int CYCLE_CAP  = 1_000_000;
    localparam int SETTLE_CYC = 40;
    localparam int DRAIN_CYC  = 200;
    localparam int TARGET     = 1450;
    localparam int LONG_HOLD  = 2500;
    // index outside the register map, the write must be dropped
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_IDX = 4'd7;

    logic                 clk;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_stall;
    logic                 cell_value;
    logic                 out_valid;
    logic                 out_stall;
    logic [OUT_W-1:0]     largest_area;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [DIM_W-1:0]     cfg_data;

    largest_island_one_flip DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .cell_value   (cell_value),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .largest_area (largest_area),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    // 10 ns clock
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Shadow of the block: raw register values, loaded cells, load pointer
    logic [DIM_W-1:0] rows_reg;
    logic [DIM_W-1:0] cols_reg;
    bit               grid_cells [CELLS];
    int               comp_of    [CELLS];
    int               comp_size  [CELLS];
    int               load_ptr;

    logic [OUT_W-1:0] area_q [$];   // pending largest_area values, oldest first
    int               typed_area;   // nonzero: hand-written answer for the grid
    int               fail_count;
    int               cycle_count;
    int               items_sent;
    bit               quiet;        // phase with no idling on either side
    bit               hold_req;     // ask the receiver for its long hold-off
    bit               long_hold_done;

    function automatic int clamp_dim(logic [DIM_W-1:0] v);
        if (v == 0)
            return 1;
        if (v > MAX_DIM)
            return MAX_DIM;
        return int'(v);
    endfunction

    // Neighbor of pos in direction d, if it lies inside the grid
    function automatic bit step_to(int pos, dir_t d, int nr, int nc, output int nb);
        int r;
        int c;
        r = pos / nc;
        c = pos % nc;
        case (d)
            DIR_UP:    r = r - 1;
            DIR_DOWN:  r = r + 1;
            DIR_LEFT:  c = c - 1;
            default:   c = c + 1;
        endcase
        nb = r * nc + c;
        return (r >= 0 && c >= 0 && r < nr && c < nc);
    endfunction

    function automatic int largest_after_flip(int nr, int nc);
        int total;
        int best;
        int sp;
        int q;
        int nb;
        int cnt;
        int sum;
        int nseen;
        int seen [4];
        bit dup;
        bit mark  [CELLS];
        int stack [CELLS];
        total = nr * nc;
        best  = 0;
        // flood-fill each component, labelled by its first raster cell
        for (int p = 0; p < total; p++)
        begin
            if (mark[p] || !grid_cells[p])
                continue;
            mark[p] = 1'b1;
            sp = 0;
            stack[sp++] = p;
            cnt = 0;
            while (sp > 0)
            begin
                q = stack[--sp];
                comp_of[q] = p;
                cnt++;
                for (int d = 0; d < 4; d++)
                    if (step_to(q, dir_t'(d), nr, nc, nb) && grid_cells[nb] && !mark[nb])
                    begin
                        mark[nb] = 1'b1;
                        stack[sp++] = nb;
                    end
            end
            comp_size[p] = cnt;
            if (cnt > best)
                best = cnt;
        end
        // try flipping every water cell
        for (int p = 0; p < total; p++)
        begin
            if (grid_cells[p])
                continue;
            sum = 1;
            nseen = 0;
            for (int d = 0; d < 4; d++)
            begin
                if (!step_to(p, dir_t'(d), nr, nc, nb) || !grid_cells[nb])
                    continue;
                dup = 1'b0;
                for (int k = 0; k < nseen; k++)
                    if (seen[k] == comp_of[nb])
                        dup = 1'b1;
                if (dup)
                    continue;
                seen[nseen++] = comp_of[nb];
                sum += comp_size[comp_of[nb]];
            end
            if (sum > best)
                best = sum;
        end
        return best;
    endfunction

    // Advance the shadow by one accepted cell; queue an answer when the grid closes
    task automatic load_cell(logic v);
        int nr;
        int nc;
        int predicted;
        logic [OUT_W-1:0] answer;
        nr = clamp_dim(rows_reg);
        nc = clamp_dim(cols_reg);
        if (load_ptr >= nr * nc)
            load_ptr = 0;
        grid_cells[load_ptr] = v;
        load_ptr++;
        if (load_ptr < nr * nc)
            return;
        load_ptr = 0;
        predicted = largest_after_flip(nr, nc);
        answer = (typed_area != 0) ? OUT_W'(typed_area) : OUT_W'(predicted);
        area_q.insert(area_q.size(), answer);
    endtask

    function automatic int gap_len();
        int r;
        if (quiet)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 65)
            return 0;
        if (r < 95)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Offer one cell beat; called and returns at a falling edge, valid left high
    task automatic send_cell(logic v);
        int g;
        g = gap_len();
        if (g > 0)
        begin
            in_valid = 1'b0;
            repeat (g) @(negedge clk);
        end
        in_valid   = 1'b1;
        cell_value = v;
        do
            @(posedge clk);
        while (in_stall);
        load_cell(v);
        items_sent++;
        @(negedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [DIM_W-1:0] val);
        in_valid  = 1'b0;
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = val;
        do
            @(posedge clk);
        while (!cfg_ready);
        if (idx == CFG_GRID_ROWS)
        begin
            rows_reg = val;
            load_ptr = 0;
        end
        else if (idx == CFG_GRID_COLS)
        begin
            cols_reg = val;
            load_ptr = 0;
        end
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    // Hold the sender until every answer is back, then let the block go quiet
    task automatic settle();
        in_valid = 1'b0;
        while (area_q.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYC) @(negedge clk);
    endtask

    // Directed grids: raw dims, cells LSB first, cells to feed, typed answer or 0
    typedef struct {
        logic [DIM_W-1:0] nrows;
        logic [DIM_W-1:0] ncols;
        logic [15:0]      pattern;
        int               feed;
        int               area;
    } grid_row_t;

    grid_row_t directed [8] = '{
        '{7'd1, 7'd1, 16'h0001, 1, 1},   // lone land
        '{7'd1, 7'd1, 16'h0000, 1, 1},   // lone water, flip it
        '{7'd0, 7'd0, 16'h0001, 1, 1},   // zero dims act as one
        '{7'd2, 7'd2, 16'h000F, 4, 4},   // all land, no water to flip
        '{7'd2, 7'd2, 16'h0000, 4, 1},   // all water
        '{7'd2, 7'd2, 16'h0005, 2, 0},   // half a grid, dropped by the next write
        '{7'd1, 7'd3, 16'h0005, 3, 3},   // flip joins two islands
        '{7'd2, 7'd3, 16'h0021, 6, 0}    // corners, predictor decides
    };

    // Stimulus
    initial
    begin
        int nr;
        int nc;
        int dens;
        int ngrids;
        int total;
        rst_n      = 1'b0;
        in_valid   = 1'b0;
        cell_value = 1'b0;
        cfg_valid  = 1'b0;
        cfg_index  = CFG_GRID_ROWS;
        cfg_data   = '0;
        rows_reg   = 7'd64;
        cols_reg   = 7'd64;
        load_ptr   = 0;
        typed_area = 0;
        quiet      = 1'b0;
        hold_req   = 1'b0;
        items_sent = 0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        foreach (directed[i])
        begin
            settle();
            write_reg(CFG_GRID_ROWS, directed[i].nrows);
            write_reg(CFG_GRID_COLS, directed[i].ncols);
            if (i == 6)
                write_reg(CFG_SPARE_IDX, 7'h7F);
            typed_area = directed[i].area;
            for (int k = 0; k < directed[i].feed; k++)
                send_cell(directed[i].pattern[k]);
        end
        settle();
        typed_area = 0;

        // Random phases: mostly small grids, a few at the size limits
        for (int ph = 0; items_sent < TARGET; ph++)
        begin
            settle();
            quiet = ($urandom_range(0, 4) == 0);
            if (ph == 0)
            begin
                nr = 127;   // saturates to the row bound
                nc = 1;
            end
            else if (ph == 1)
            begin
                nr = 1;
                nc = 64;
            end
            else if (ph == 2)
            begin
                nr = 3;     // small grids that back up behind the long hold-off
                nc = 3;
            end
            else if ($urandom_range(0, 9) == 0)
            begin
                nr = $urandom_range(64, 127);
                nc = $urandom_range(0, 4);
                if ($urandom_range(0, 1))
                begin
                    nc = nr;
                    nr = $urandom_range(0, 4);
                end
            end
            else
            begin
                nr = $urandom_range(0, 8);
                nc = $urandom_range(0, 8);
            end
            if ($urandom_range(0, 4) == 0)
                write_reg(CFG_SPARE_IDX, 7'($urandom_range(0, 127)));
            write_reg(CFG_GRID_ROWS, 7'(nr));
            write_reg(CFG_GRID_COLS, 7'(nc));
            total  = clamp_dim(7'(nr)) * clamp_dim(7'(nc));
            ngrids = $urandom_range(1, 5);
            if (ph == 2)
            begin
                ngrids   = 5;
                hold_req = 1'b1;
            end
            for (int g = 0; g < ngrids && items_sent < TARGET; g++)
            begin
                dens = $urandom_range(0, 100);
                for (int k = 0; k < total; k++)
                    send_cell($urandom_range(0, 99) < dens);
            end
            // drop a trailing partial grid now and then
            if ($urandom_range(0, 9) == 0 && total > 1)
                for (int k = 0; k < $urandom_range(1, total - 1); k++)
                    send_cell($urandom_range(0, 1));
        end

        in_valid = 1'b0;
        while (area_q.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYC) @(negedge clk);
        if (fail_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    // Receiver stall pattern, with one long hold-off so the block backs up
    initial
    begin
        int stall_left;
        stall_left     = 0;
        long_hold_done = 1'b0;
        out_stall      = 1'b0;
        forever
        begin
            @(negedge clk);
            if (!long_hold_done && hold_req)
            begin
                long_hold_done = 1'b1;
                stall_left     = LONG_HOLD;
            end
            if (stall_left == 0 && !quiet)
            begin
                int r;
                r = $urandom_range(0, 99);
                if (r >= 97)
                    stall_left = $urandom_range(20, 80);
                else if (r >= 75)
                    stall_left = $urandom_range(1, 4);
            end
            out_stall = (stall_left > 0);
            if (stall_left > 0)
                stall_left--;
        end
    end

    // Check each result beat against the oldest pending answer
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (area_q.size() == 0)
            begin
                $error("unexpected result beat: largest_area=%0d", largest_area);
                fail_count++;
            end
            else
            begin
                logic [OUT_W-1:0] want;
                want = area_q.pop_front();
                if (largest_area !== want)
                begin
                    $error("largest_area: expected %0d, actual %0d", want, largest_area);
                    fail_count++;
                end
            end
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_CAP)
        begin
            $display("FAIL");
            $finish;
        end
    end

    initial
    begin
        fail_count  = 0;
        cycle_count = 0;
    end

endmodule
